/* hw/rtl/fimrx_pkg.sv */
package fimrx_pkg;

	// Default width of the reported payload offset
	localparam int OFFSET_BITS_DEF = 16;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAGE_LEN   = 4'd1;
	localparam logic [15:0] MAX_PAYLOAD_LEN_RST = 16'(48 * 1024);
	localparam logic [23:0] MAX_IMAGE_LEN_RST   = 24'(192 * 1024);

	// CRC-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Frame status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_CRC_BAD   = 2'd2;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Frame marker, matched first byte first
	localparam logic [7:0] MARKER [0:3] = '{8'h52, 8'h50, 8'h42, 8'h4C};

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_word_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] offset;
		logic        last;
		logic [1:0]  status;
		logic [23:0] image_len;
	} res_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [31:0]          value;
	} cfg_word_t;

	typedef struct packed {
		logic [15:0] max_payload_len;
		logic [23:0] max_image_len;
	} limits_t;

	// Advance a reflected CRC-32 by one byte
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/fimrx_chan_if.sv */
interface fimrx_chan_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/fimrx_parse.sv */
module fimrx_parse #(
	parameter int OFFSET_BITS = fimrx_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fimrx_pkg::limits_t  limits,
	input  logic [7:0]          rx_byte,
	input  logic                step,
	output logic                hit,
	output fimrx_pkg::res_word_t res_word
);
	import fimrx_pkg::*;

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_HEADER  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [3:0] HDR_LAST   = 4'd11;
	localparam logic [15:0] OFF_MASK  = (OFFSET_BITS >= 16) ? 16'hFFFF :
		16'((32'd1 << OFFSET_BITS) - 32'd1);

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  magic_q, magic_d;
	logic [3:0]  hdr_cnt_q, hdr_cnt_d;
	logic [15:0] pay_cnt_q, pay_cnt_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] pay_len_q, pay_len_d;
	logic [31:0] img_len_q, img_len_d;
	logic [31:0] exp_crc_q, exp_crc_d;

	logic [31:0] crc_nx;
	logic [31:0] exp_fin;
	logic        too_large;
	logic        pay_end;
	logic [1:0]  lane;

	assign crc_nx    = crc32_byte(crc_q, rx_byte);
	assign exp_fin   = {rx_byte, exp_crc_q[23:0]};
	assign too_large = (pay_len_q > {16'd0, limits.max_payload_len}) ||
		(img_len_q > {8'd0, limits.max_image_len});
	assign pay_end   = (({16'd0, pay_cnt_q} + 32'd1) >= pay_len_q);
	assign lane      = hdr_cnt_q[1:0];

	// Decode one byte against the frame state
	always_comb begin
		phase_d   = phase_q;
		magic_d   = magic_q;
		hdr_cnt_d = hdr_cnt_q;
		pay_cnt_d = pay_cnt_q;
		crc_d     = crc_q;
		pay_len_d = pay_len_q;
		img_len_d = img_len_q;
		exp_crc_d = exp_crc_q;
		hit       = 1'b0;
		res_word  = '{kind: KIND_END, data_byte: 8'd0, offset: 16'd0, last: 1'b1,
			status: ST_OK, image_len: img_len_q[23:0]};
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == MARKER[magic_q]) begin
					if (magic_q == 2'd3) begin
						magic_d   = 2'd0;
						phase_d   = PH_HEADER;
						hdr_cnt_d = 4'd0;
					end else begin
						magic_d = magic_q + 2'd1;
					end
				end else begin
					magic_d = (rx_byte == MARKER[0]) ? 2'd1 : 2'd0;
				end
			end
			PH_HEADER: begin
				// Gather the three little-endian header words
				case (hdr_cnt_q[3:2])
					2'd0:    pay_len_d[8*lane +: 8] = rx_byte;
					2'd1:    img_len_d[8*lane +: 8] = rx_byte;
					default: exp_crc_d[8*lane +: 8] = rx_byte;
				endcase
				hdr_cnt_d = hdr_cnt_q + 4'd1;
				if (hdr_cnt_q == HDR_LAST) begin
					if (too_large || pay_len_q == 32'd0) begin
						hit = 1'b1;
						if (too_large) begin
							res_word.status = ST_TOO_LARGE;
						end else begin
							res_word.status = (exp_fin == 32'd0) ? ST_OK : ST_CRC_BAD;
						end
						phase_d   = PH_HUNT;
						magic_d   = 2'd0;
						hdr_cnt_d = 4'd0;
						pay_cnt_d = 16'd0;
						crc_d     = CRC_INIT;
					end else begin
						phase_d   = PH_PAYLOAD;
						pay_cnt_d = 16'd0;
						crc_d     = CRC_INIT;
					end
				end
			end
			PH_PAYLOAD: begin
				// Pass the byte on and fold it into the CRC
				hit                = 1'b1;
				res_word.kind      = KIND_DATA;
				res_word.data_byte = rx_byte;
				res_word.offset    = pay_cnt_q & OFF_MASK;
				crc_d              = crc_nx;
				if (pay_end) begin
					res_word.last   = 1'b1;
					res_word.status = ((~crc_nx) == exp_crc_q) ? ST_OK : ST_CRC_BAD;
					phase_d   = PH_HUNT;
					magic_d   = 2'd0;
					hdr_cnt_d = 4'd0;
					pay_cnt_d = 16'd0;
					crc_d     = CRC_INIT;
				end else begin
					res_word.last = 1'b0;
					pay_cnt_d     = pay_cnt_q + 16'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// Advance control state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			magic_q   <= 2'd0;
			hdr_cnt_q <= 4'd0;
			pay_cnt_q <= 16'd0;
			crc_q     <= CRC_INIT;
		end else if (step) begin
			phase_q   <= phase_d;
			magic_q   <= magic_d;
			hdr_cnt_q <= hdr_cnt_d;
			pay_cnt_q <= pay_cnt_d;
			crc_q     <= crc_d;
		end
	end

	// Hold the header words
	always_ff @(posedge clk) begin
		if (step) begin
			pay_len_q <= pay_len_d;
			img_len_q <= img_len_d;
			exp_crc_q <= exp_crc_d;
		end
	end

endmodule

/* hw/rtl/framed_image_receiver_crc32_top.sv */
// Framed image receiver: takes one received byte per word on rx, hunts for the four-byte
// frame marker, gathers the twelve header bytes (payload length, image length, expected CRC,
// all little endian) and then forwards each payload byte on res with its offset while a
// reflected CRC-32 runs over the payload. The final word of a frame has last set and carries
// the status: OK, length too large (a frame-end word without data) or CRC mismatch. The block
// takes one byte per clock cycle unless res stalls; a byte enters an input register and is
// then decoded by the framing logic and the byte-wide CRC update, which load the result
// register. A stall on res holds the input only when the waiting byte itself produces a
// result. Limits are written on cfg (index 0: payload limit, index 1: image limit); the user
// must write them only while no frame is in flight, as the block itself does not enforce it.
module framed_image_receiver_crc32_top #(
	parameter int OFFSET_BITS = fimrx_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fimrx_chan_if.sink   rx,
	fimrx_chan_if.source res,
	fimrx_chan_if.sink   cfg
);
	import fimrx_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       res_valid_q;
	res_word_t  res_q;
	limits_t    limits_q;

	logic       hit;
	res_word_t  res_word;
	logic       out_free;
	logic       adv;
	rx_word_t   rx_word;
	cfg_word_t  cfg_word;

	assign rx_word  = rx.data;
	assign cfg_word = cfg.data;
	assign out_free = !res_valid_q || res.ready;
	assign adv      = valid_s1 && (!hit || out_free);
	assign rx.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// Write the limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_payload_len <= MAX_PAYLOAD_LEN_RST;
			limits_q.max_image_len   <= MAX_IMAGE_LEN_RST;
		end else if (cfg.valid) begin
			unique case (cfg_word.index)
				CFG_MAX_PAYLOAD_LEN: limits_q.max_payload_len <= cfg_word.value[15:0];
				CFG_MAX_IMAGE_LEN:   limits_q.max_image_len   <= cfg_word.value[23:0];
				default: ;
			endcase
		end
	end

	// Hold the input byte until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx_word.rx_byte;
		end
	end

	fimrx_parse #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.limits   (limits_q),
		.rx_byte  (rx_byte_s1),
		.step     (adv),
		.hit      (hit),
		.res_word (res_word)
	);

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= adv && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			res_q <= res_word;
		end
	end

	// A stalled byte stays in the input register unchanged
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input byte lost while stalled");

	// Every processed byte that yields a result shows up on res
	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv && hit |=> res_valid_q)
		else $error("result not loaded");

	// A result not taken stays pending
	a_res_keep: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |=> res_valid_q && $stable(res_q))
		else $error("pending result dropped");

	// An empty input register always takes a byte
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("input blocked while empty");

endmodule

/* dv/tb_framed_image_receiver_crc32_top.sv */
module tb_framed_image_receiver_crc32_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fimrx_pkg::*;

	typedef enum logic [1:0] {
		HUNT_MARKER,
		READ_HEADER,
		PASS_PAYLOAD
	} rx_phase_t;

	// Indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 4'd15;

	localparam int RANDOM_BYTES_PER_SETTING = 60;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;

	fimrx_chan_if #(.T(rx_word_t))  rx_if ();
	fimrx_chan_if #(.T(res_word_t)) res_if ();
	fimrx_chan_if #(.T(cfg_word_t)) cfg_if ();

	framed_image_receiver_crc32_top #(
		.OFFSET_BITS(OFFSET_BITS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	// Shadow of the receiver state
	rx_phase_t   m_phase;
	logic [2:0]  m_marker_cnt;
	logic [3:0]  m_hdr_cnt;
	logic [31:0] m_pay_len;
	logic [31:0] m_img_len;
	logic [31:0] m_crc_want;
	logic [31:0] m_crc_run;
	logic [15:0] m_pay_cnt;
	limits_t     m_lim;

	res_word_t   due_words[$];
	logic [7:0]  payload_buf[$];
	int unsigned err_cnt;
	int unsigned bytes_sent;
	bit          idle_on;

	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned draw_gap();
		return idle_on ? $urandom_range(0, 6) : 0;
	endfunction

	// Reflected CRC-32, one input bit at a time
	function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ b[i]) begin
				r = {1'b0, r[31:1]} ^ CRC_POLY;
			end else begin
				r = {1'b0, r[31:1]};
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] payload_crc();
		logic [31:0] c;
		c = CRC_INIT;
		foreach (payload_buf[i]) c = crc_step(c, payload_buf[i]);
		return ~c;
	endfunction

	function automatic void push_due(logic k, logic [7:0] d, logic [15:0] off, logic lst,
			logic [1:0] st);
		res_word_t w;
		w.kind      = k;
		w.data_byte = d;
		w.offset    = off;
		w.last      = lst;
		w.status    = st;
		w.image_len = m_img_len[23:0];
		due_words.push_back(w);
	endfunction

	function automatic void return_to_hunt();
		m_phase      = HUNT_MARKER;
		m_marker_cnt = '0;
		m_hdr_cnt    = '0;
		m_pay_cnt    = '0;
		m_crc_run    = CRC_INIT;
	endfunction

	function automatic void model_reset();
		m_lim.max_payload_len = MAX_PAYLOAD_LEN_RST;
		m_lim.max_image_len   = MAX_IMAGE_LEN_RST;
		m_pay_len  = '0;
		m_img_len  = '0;
		m_crc_want = '0;
		return_to_hunt();
	endfunction

	// Advance the shadow state by one accepted byte and queue the word it causes
	function automatic void decode_rx_byte(logic [7:0] b);
		logic [1:0]  pos;
		logic [4:0]  sh;
		logic [31:0] fin;
		case (m_phase)
			HUNT_MARKER: begin
				pos = m_marker_cnt[1:0];
				if (b == MARKER[pos]) begin
					m_marker_cnt = {1'b0, pos} + 3'd1;
				end else begin
					m_marker_cnt = (b == MARKER[0]) ? 3'd1 : 3'd0;
				end
				if (m_marker_cnt == 3'd4) begin
					m_marker_cnt = '0;
					m_phase      = READ_HEADER;
					m_hdr_cnt    = '0;
				end
			end
			READ_HEADER: begin
				sh = {m_hdr_cnt[1:0], 3'b000};
				if (m_hdr_cnt < 4) begin
					m_pay_len[sh +: 8] = b;
				end else if (m_hdr_cnt < 8) begin
					m_img_len[sh +: 8] = b;
				end else begin
					m_crc_want[sh +: 8] = b;
				end
				m_hdr_cnt = m_hdr_cnt + 4'd1;
				if (m_hdr_cnt == 4'd12) begin
					// Lengths are judged at full width against the limits
					if (m_pay_len > {16'd0, m_lim.max_payload_len} ||
							m_img_len > {8'd0, m_lim.max_image_len}) begin
						push_due(KIND_END, 8'd0, 16'd0, 1'b1, ST_TOO_LARGE);
						return_to_hunt();
					end else if (m_pay_len == 32'd0) begin
						push_due(KIND_END, 8'd0, 16'd0, 1'b1,
							(m_crc_want == 32'd0) ? ST_OK : ST_CRC_BAD);
						return_to_hunt();
					end else begin
						m_phase   = PASS_PAYLOAD;
						m_pay_cnt = '0;
						m_crc_run = CRC_INIT;
					end
				end
			end
			default: begin
				m_crc_run = crc_step(m_crc_run, b);
				if ({16'd0, m_pay_cnt} + 32'd1 >= m_pay_len) begin
					fin = ~m_crc_run;
					push_due(KIND_DATA, b, m_pay_cnt, 1'b1,
						(fin == m_crc_want) ? ST_OK : ST_CRC_BAD);
					return_to_hunt();
				end else begin
					push_due(KIND_DATA, b, m_pay_cnt, 1'b0, ST_OK);
					m_pay_cnt = m_pay_cnt + 16'd1;
				end
			end
		endcase
	endfunction

	function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	function automatic void check_word(res_word_t got);
		res_word_t want;
		if (due_words.size() == 0) begin
			$error("result word with none due: %p", got);
			err_cnt++;
			return;
		end
		want = due_words.pop_front();
		cmp_field("kind", want.kind, got.kind);
		cmp_field("data_byte", want.data_byte, got.data_byte);
		cmp_field("offset", want.offset, got.offset);
		cmp_field("last", want.last, got.last);
		cmp_field("status", want.status, got.status);
		cmp_field("image_len", want.image_len, got.image_len);
	endfunction

	// Result sink: check each word, then hold ready low for a drawn number of cycles
	initial begin
		int unsigned hold;
		hold = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_if.valid && res_if.ready) begin
					check_word(res_if.data);
					hold = draw_gap();
					res_if.ready <= (hold == 0);
				end else if (!res_if.ready) begin
					if (hold <= 1) res_if.ready <= 1'b1;
					if (hold != 0) hold--;
				end
			end
		end
	end

	// Offer one byte after a drawn gap; valid stays high for a back-to-back word
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid        <= 1'b1;
		rx_if.data.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		decode_rx_byte(b);
		bytes_sent++;
	endtask

	// Drop valid, then wait for every due word
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (due_words.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		wait_drained();
		repeat (4) @(posedge clk);
	endtask

	task automatic send_le(logic [31:0] w);
		for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
	endtask

	// Marker, header, then whatever sits in the payload buffer
	task automatic send_frame(logic [31:0] plen, logic [31:0] ilen, logic [31:0] crc,
			int pause_at);
		foreach (MARKER[i]) send_byte(MARKER[i]);
		send_le(plen);
		send_le(ilen);
		send_le(crc);
		foreach (payload_buf[i]) begin
			if (i == pause_at) wait_drained();
			send_byte(payload_buf[i]);
		end
	endtask

	task automatic fill_payload(int unsigned n);
		payload_buf.delete();
		repeat (n) payload_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic good_frame(int unsigned n, logic [31:0] ilen, bit corrupt, int pause_at);
		logic [31:0] crc;
		fill_payload(n);
		crc = payload_crc();
		if (corrupt) crc ^= 32'h1 << $urandom_range(0, 31);
		send_frame(n, ilen, crc, pause_at);
	endtask

	// Push bytes until the shadow state is back to hunting
	task automatic finish_frame();
		while (m_phase != HUNT_MARKER) begin
			if (m_phase == READ_HEADER) begin
				send_byte(8'hFF);
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		finish_frame();
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= cfg_word_t'{index: idx, value: val};
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == CFG_MAX_PAYLOAD_LEN) begin
			m_lim.max_payload_len = val[15:0];
		end else if (idx == CFG_MAX_IMAGE_LEN) begin
			m_lim.max_image_len = val[23:0];
		end
	endtask

	// Broken and restarted markers ahead of an empty frame
	task automatic test_marker_hunt();
		logic [7:0] lead[$];
		lead = '{MARKER[0], MARKER[0], MARKER[1], MARKER[2], 8'h00,
			MARKER[0], MARKER[1], MARKER[2], MARKER[0]};
		foreach (lead[i]) send_byte(lead[i]);
		payload_buf.delete();
		send_frame(32'd0, 32'd0, 32'd0, -1);
	endtask

	task automatic test_empty_payload();
		payload_buf.delete();
		send_frame(32'd0, {8'd0, MAX_IMAGE_LEN_RST}, 32'd0, -1);
		send_frame(32'd0, 32'd5, 32'h8000_0001, -1);
	endtask

	task automatic test_short_payload();
		payload_buf = '{8'hFF};
		send_frame(32'd1, 32'd0, payload_crc(), -1);
		payload_buf = '{8'h00};
		send_frame(32'd1, 32'd0, payload_crc() ^ 32'h1, -1);
		good_frame(3, 32'd100, 1'b0, -1);
	endtask

	// Default limits, exceeded by one and in the upper header bytes
	task automatic test_length_limits();
		payload_buf.delete();
		send_frame({16'd0, MAX_PAYLOAD_LEN_RST} + 32'd1, 32'd0, 32'd0, -1);
		send_frame(32'h0100_0000, 32'd0, 32'd0, -1);
		send_frame(32'd1, {8'd0, MAX_IMAGE_LEN_RST} + 32'd1, 32'd0, -1);
		send_frame(32'd1, 32'h8000_0000, 32'd0, -1);
	endtask

	task automatic test_limit_registers();
		cfg_write(CFG_MAX_PAYLOAD_LEN, 32'h0);
		payload_buf.delete();
		send_frame(32'd1, 32'd0, 32'd0, -1);
		send_frame(32'd0, 32'd0, 32'd0, -1);

		// Upper value bits fall outside the register
		cfg_write(CFG_MAX_PAYLOAD_LEN, 32'hABCD_0004);
		good_frame(4, 32'd7, 1'b0, -1);
		payload_buf.delete();
		send_frame(32'd5, 32'd0, 32'd0, -1);

		cfg_write(CFG_MAX_IMAGE_LEN, 32'h0);
		send_frame(32'd0, 32'd1, 32'd0, -1);
		send_frame(32'd0, 32'd0, 32'd0, -1);

		cfg_write(CFG_MAX_IMAGE_LEN, 32'h5AFF_FFFF);
		send_frame(32'd0, 32'h00FF_FFFF, 32'd0, -1);
		send_frame(32'd0, 32'h0100_0000, 32'd0, -1);

		// Writes to unused indexes must leave both limits alone
		cfg_write(CFG_IDX_UNUSED_LO, 32'h0);
		cfg_write(CFG_IDX_UNUSED_HI, 32'h0);
		good_frame(3, 32'd3, 1'b0, -1);
	endtask

	// Payload right at the limit, sent back to back; pause the sender halfway
	task automatic test_max_payload();
		cfg_write(CFG_MAX_PAYLOAD_LEN, 32'd48);
		idle_on = 1'b0;
		good_frame(48, 32'd0, 1'b0, 24);
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned start;
		int unsigned pick;
		int unsigned n;
		logic [31:0] plen;
		logic [31:0] ilen;
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin
					cfg_write(CFG_MAX_PAYLOAD_LEN, $urandom_range(8, 40));
					cfg_write(CFG_MAX_IMAGE_LEN, $urandom());
				end
				1: begin
					cfg_write(CFG_MAX_PAYLOAD_LEN, 32'hFFFF);
					cfg_write(CFG_MAX_IMAGE_LEN, 32'hFF_FFFF);
				end
				default: begin
					cfg_write(CFG_MAX_PAYLOAD_LEN, MAX_PAYLOAD_LEN_RST);
					cfg_write(CFG_MAX_IMAGE_LEN, MAX_IMAGE_LEN_RST);
				end
			endcase
			start = bytes_sent;
			while (bytes_sent - start < RANDOM_BYTES_PER_SETTING) begin
				idle_on = ($urandom_range(0, 3) != 0);
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					// Well-formed frame, now and then with a bad CRC or a sender pause
					n = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 24);
					if (n > m_lim.max_payload_len) n = m_lim.max_payload_len;
					ilen = $urandom_range(0, m_lim.max_image_len);
					good_frame(n, ilen, $urandom_range(0, 4) == 0,
						($urandom_range(0, 11) == 0) ? int'(n / 2) : -1);
				end else if (pick < 75) begin
					payload_buf.delete();
					send_frame(32'd0, $urandom_range(0, m_lim.max_image_len),
						($urandom_range(0, 1) != 0) ? $urandom() : 32'd0, -1);
				end else if (pick < 87) begin
					// Oversized header followed by stray bytes
					case ($urandom_range(0, 2))
						0: begin
							plen = m_lim.max_payload_len + $urandom_range(1, 300);
							ilen = $urandom_range(0, m_lim.max_image_len);
						end
						1: begin
							plen = $urandom_range(0, m_lim.max_payload_len);
							ilen = m_lim.max_image_len + $urandom_range(1, 1000);
						end
						default: begin
							plen = $urandom();
							ilen = $urandom();
						end
					endcase
					fill_payload($urandom_range(0, 4));
					send_frame(plen, ilen, $urandom(), -1);
				end else begin
					// Noise laced with marker bytes; keep it out of the byte budget
					n = $urandom_range(1, 8);
					start += n;
					repeat (n) begin
						if ($urandom_range(0, 2) == 0) begin
							send_byte(MARKER[$urandom_range(0, 3)]);
						end else begin
							send_byte(8'($urandom_range(0, 255)));
						end
					end
				end
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		rx_if.valid  = 1'b0;
		rx_if.data   = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data  = '0;
		err_cnt      = 0;
		bytes_sent   = 0;
		idle_on      = 1'b1;
		model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_marker_hunt();
		test_empty_payload();
		test_short_payload();
		test_length_limits();
		test_limit_registers();
		test_max_payload();
		test_random_traffic();

		// Drain and watch for stray words
		finish_frame();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
